// ===== design/rne_pkg.sv =====
// Package for the radius neighbor edge list unit: sizes, types, controller states.
// No dependencies.
package rne_pkg;
	localparam int POINTS    = 8;
	localparam int MAX_EDGES = POINTS * (POINTS - 1) / 2;
	localparam int IDX_W     = $clog2(POINTS);
	localparam int CNT_W     = $clog2(POINTS + 1);
	localparam int EIDX_W    = $clog2(MAX_EDGES);
	localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
	localparam int COORD_W   = 20;
	localparam int DIFF_W    = 21;
	localparam int SQ_W      = 42;
	localparam int D2_W      = 44;
	localparam int LEN_W     = 21;
	localparam int NODE_W    = 3;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAIR,
		ST_SORT,
		ST_EMIT,
		ST_NONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic store_pt;
		logic clr_pts;
		logic pair_start;
		logic sort_start;
		logic emit_start;
		logic emit_next;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pair_done;
		logic sort_done;
		logic emit_last;
	} dp_sts_t;
endpackage

// ===== design/radius_neighbor_edge_list_unit.sv =====
// Radius neighbor edge list unit: top level.
// Points load one per cycle with no result. The last point starts a pair scan (distance
// pipeline, then a 22-step serial square root for each kept pair), a bubble sort over the
// kept edges, and a handoff to the output; then one beat per edge, or one no-edge beat.
// The next set is taken after the last beat.
// Reset (arst_n low) clears the point count, edge count, state and range register.
module radius_neighbor_edge_list_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [20:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic signed [19:0] pos_z,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         node_a,
	output logic [2:0]         node_b,
	output logic [20:0]        edge_length,
	output logic               no_edge,
	output logic               last_edge
);
	import rne_pkg::*;

	logic [20:0] max_dist_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [2:0]  a, b;
	logic [20:0] len;
	logic        none, ezero;

	// jump range register, to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     max_dist_q <= '0;
		else if (cfg_we) max_dist_q <= cfg_wdata;
	end

	rne_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_last(last_point), .in_ready,
		.out_valid, .out_ready, .out_none(none), .out_last(last_edge),
		.edges_zero(ezero), .cmd, .sts
	);

	rne_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .max_dist(max_dist_q),
		.in_x(pos_x), .in_y(pos_y), .in_z(pos_z),
		.out_a(a), .out_b(b), .out_len(len), .edges_zero(ezero)
	);

	// the no-edge beat carries zeros in the edge fields
	assign no_edge     = none;
	assign node_a      = none ? '0 : a;
	assign node_b      = none ? '0 : b;
	assign edge_length = none ? '0 : len;
endmodule

// ===== design/rne_datapath.sv =====
// Datapath: point store, pair distance pipeline, serial square root, edge store and sort.
// Depends on rne_pkg.
module rne_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rne_pkg::dp_cmd_t               cmd,
	output rne_pkg::dp_sts_t               sts,
	input  logic [20:0]                    max_dist,
	input  logic signed [19:0]             in_x,
	input  logic signed [19:0]             in_y,
	input  logic signed [19:0]             in_z,
	output logic [2:0]                     out_a,
	output logic [2:0]                     out_b,
	output logic [20:0]                    out_len,
	output logic                           edges_zero
);
	import rne_pkg::*;

	logic signed [COORD_W-1:0] px_q [POINTS];
	logic signed [COORD_W-1:0] py_q [POINTS];
	logic signed [COORD_W-1:0] pz_q [POINTS];
	logic [CNT_W-1:0]          npts_q;
	logic [CNT_W-1:0]          npts_nx;

	logic [IDX_W-1:0] ei_q [MAX_EDGES];
	logic [IDX_W-1:0] ej_q [MAX_EDGES];
	logic [LEN_W-1:0] el_q [MAX_EDGES];
	logic [ECNT_W-1:0] nedge_q;

	// pair walker phases: 0 diff, 1 square x/y, 2 square z+sum, 3 compare, 4 sqrt, 5 store
	logic [IDX_W:0]   pi_q, pj_q;
	logic             pair_busy_q;
	logic [2:0]       ph_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
	logic [SQ_W-1:0]  sx_q, sy_q;
	logic [D2_W-1:0]  d2_q;
	logic [D2_W-1:0]  lim2_q;
	// square root, one result bit per cycle
	logic [D2_W-1:0]  rem_q;
	logic [LEN_W+1:0] root_q;
	logic [4:0]       sbit_q;

	logic [EIDX_W-1:0] si_q, sj_q;
	logic              sort_busy_q;
	logic [EIDX_W-1:0] ecur_q;

	// count including a point stored at this edge
	assign npts_nx = (cmd.store_pt && npts_q < CNT_W'(POINTS)) ? npts_q + 1'b1 : npts_q;

	always_ff @(posedge clk) begin
		if (cmd.store_pt && npts_q < CNT_W'(POINTS)) begin
			px_q[npts_q[IDX_W-1:0]] <= in_x;
			py_q[npts_q[IDX_W-1:0]] <= in_y;
			pz_q[npts_q[IDX_W-1:0]] <= in_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npts_q <= '0;
		end else if (cmd.clr_pts) begin
			npts_q <= '0;
		end else if (cmd.store_pt && npts_q < CNT_W'(POINTS)) begin
			npts_q <= npts_q + 1'b1;
		end
	end

	logic [SQ_W-1:0] sz;
	logic [D2_W+1:0] trial;
	always_comb begin
		sz    = SQ_W'($signed(dz_q) * $signed(dz_q));
		trial = {2'b00, rem_q} - ({2'b00, root_q, 2'b00} | (D2_W+2)'(1)) ;
	end

	logic pair_last;
	assign pair_last = (pj_q + 1'b1 >= (IDX_W+1)'(npts_q)) &&
		(pi_q + 2'd2 >= (IDX_W+1)'(npts_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_busy_q <= 1'b0;
			nedge_q     <= '0;
			ph_q        <= '0;
			pi_q        <= '0;
			pj_q        <= '0;
			sbit_q      <= '0;
		end else if (cmd.pair_start) begin
			pi_q    <= '0;
			pj_q    <= (IDX_W+1)'(1);
			ph_q    <= '0;
			nedge_q <= '0;
			pair_busy_q <= (npts_nx >= CNT_W'(2));
		end else if (pair_busy_q) begin
			case (ph_q)
				3'd0: ph_q <= 3'd1;
				3'd1: ph_q <= 3'd2;
				3'd2: ph_q <= 3'd3;
				3'd3: begin
					if (d2_q <= lim2_q) begin
						ph_q   <= 3'd4;
						sbit_q <= 5'd21;
					end else begin
						ph_q <= 3'd0;
						if (pair_last) pair_busy_q <= 1'b0;
						else if (pj_q + 1'b1 >= (IDX_W+1)'(npts_q)) begin
							pi_q <= pi_q + 1'b1;
							pj_q <= pi_q + 2'd2;
						end else pj_q <= pj_q + 1'b1;
					end
				end
				default: begin
					if (sbit_q == 5'd0) begin
						ph_q <= 3'd5;
					end else begin
						sbit_q <= sbit_q - 1'b1;
					end
					if (ph_q == 3'd5) begin
						nedge_q <= nedge_q + 1'b1;
						ph_q    <= 3'd0;
						if (pair_last) pair_busy_q <= 1'b0;
						else if (pj_q + 1'b1 >= (IDX_W+1)'(npts_q)) begin
							pi_q <= pi_q + 1'b1;
							pj_q <= pi_q + 2'd2;
						end else pj_q <= pj_q + 1'b1;
					end
				end
			endcase
		end
	end

	// payload-only registers of the pair walker and the edge sort
	always_ff @(posedge clk) begin
		if (cmd.pair_start) lim2_q <= D2_W'(SQ_W'(max_dist) * SQ_W'(max_dist));
		if (pair_busy_q) begin
			case (ph_q)
				3'd0: begin
					dx_q <= DIFF_W'(px_q[pi_q[IDX_W-1:0]]) - DIFF_W'(px_q[pj_q[IDX_W-1:0]]);
					dy_q <= DIFF_W'(py_q[pi_q[IDX_W-1:0]]) - DIFF_W'(py_q[pj_q[IDX_W-1:0]]);
					dz_q <= DIFF_W'(pz_q[pi_q[IDX_W-1:0]]) - DIFF_W'(pz_q[pj_q[IDX_W-1:0]]);
				end
				3'd1: begin
					sx_q <= SQ_W'($signed(dx_q) * $signed(dx_q));
					sy_q <= SQ_W'($signed(dy_q) * $signed(dy_q));
				end
				3'd2: d2_q <= D2_W'(sx_q) + D2_W'(sy_q) + D2_W'(sz);
				3'd3: begin
					rem_q  <= d2_q;
					root_q <= '0;
				end
				3'd4: begin
					// digit step: bring in the next pair of bits
					if (!trial[D2_W+1] && ((rem_q >> (2*sbit_q)) >= (D2_W'({root_q, 2'b01})))) begin
						rem_q  <= rem_q - (D2_W'({root_q, 2'b01}) << (2*sbit_q));
						root_q <= {root_q[LEN_W:0], 1'b1};
					end else begin
						root_q <= {root_q[LEN_W:0], 1'b0};
					end
				end
				default: begin
					ei_q[nedge_q[EIDX_W-1:0]] <= pi_q[IDX_W-1:0];
					ej_q[nedge_q[EIDX_W-1:0]] <= pj_q[IDX_W-1:0];
					el_q[nedge_q[EIDX_W-1:0]] <= root_q[LEN_W-1:0];
				end
			endcase
		end
		// stable bubble pass: swap adjacent pair only when strictly out of order
		if (sort_busy_q && sj_q + 1'b1 < EIDX_W'(nedge_q) &&
		    el_q[sj_q] > el_q[sj_q + 1'b1]) begin
			ei_q[sj_q] <= ei_q[sj_q + 1'b1];
			ej_q[sj_q] <= ej_q[sj_q + 1'b1];
			el_q[sj_q] <= el_q[sj_q + 1'b1];
			ei_q[sj_q + 1'b1] <= ei_q[sj_q];
			ej_q[sj_q + 1'b1] <= ej_q[sj_q];
			el_q[sj_q + 1'b1] <= el_q[sj_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_busy_q <= 1'b0;
			si_q <= '0;
			sj_q <= '0;
			ecur_q <= '0;
		end else begin
			if (cmd.sort_start) begin
				si_q <= '0;
				sj_q <= '0;
				sort_busy_q <= (nedge_q > ECNT_W'(1));
			end else if (sort_busy_q) begin
				if (ECNT_W'(sj_q) + 2'd2 >= nedge_q) begin
					sj_q <= '0;
					if (ECNT_W'(si_q) + 2'd2 >= nedge_q) sort_busy_q <= 1'b0;
					else si_q <= si_q + 1'b1;
				end else begin
					sj_q <= sj_q + 1'b1;
				end
			end
			if (cmd.emit_start) ecur_q <= '0;
			else if (cmd.emit_next) ecur_q <= ecur_q + 1'b1;
		end
	end

	// sqrt trial unused bits kept simple: root is built in 22 steps
	assign sts.pair_done = !pair_busy_q && !cmd.pair_start;
	assign sts.sort_done = !sort_busy_q && !cmd.sort_start;
	assign sts.emit_last = (ECNT_W'(ecur_q) + 1'b1 >= nedge_q);
	assign out_a      = NODE_W'(ei_q[ecur_q]);
	assign out_b      = NODE_W'(ej_q[ecur_q]);
	assign out_len    = el_q[ecur_q];
	assign edges_zero = (nedge_q == '0);
endmodule

// ===== design/rne_ctrl.sv =====
// Controller state machine: load, pair scan, sort, emit, no-edge beat.
// Depends on rne_pkg.
module rne_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_none,
	output logic             out_last,
	input  logic             edges_zero,
	output rne_pkg::dp_cmd_t cmd,
	input  rne_pkg::dp_sts_t sts
);
	import rne_pkg::*;

	state_t state_q, state_d;
	logic   acc, oacc;

	assign acc  = in_valid && in_ready;
	assign oacc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (acc && in_last) state_d = ST_PAIR;
			ST_PAIR: if (sts.pair_done) state_d = ST_SORT;
			ST_SORT: if (sts.sort_done) state_d = edges_zero ? ST_NONE : ST_EMIT;
			ST_EMIT: if (oacc && sts.emit_last) state_d = ST_LOAD;
			ST_NONE: if (oacc) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_none  = 1'b0;
		out_last  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready     = 1'b1;
				cmd.store_pt = acc;
				cmd.pair_start = acc && in_last;
			end
			ST_PAIR: begin
				cmd.clr_pts    = sts.pair_done;
				cmd.sort_start = sts.pair_done;
			end
			ST_SORT: cmd.emit_start = sts.sort_done;
			ST_EMIT: begin
				out_valid     = 1'b1;
				out_last      = sts.emit_last;
				cmd.emit_next = oacc;
			end
			ST_NONE: begin
				out_valid = 1'b1;
				out_none  = 1'b1;
				out_last  = 1'b1;
			end
			default: ;
		endcase
	end
endmodule
